// File: rtl/pjm_pkg.sv
// ----------------------------------------------------------------------------
// pjm_pkg
// Shared widths, operation codes and status codes of the periodic jitter
// monitor table.
// ----------------------------------------------------------------------------
`default_nettype none

package pjm_pkg;

	// default number of monitor slots
	localparam int MONITOR_COUNT_DEF = 8;

	// field widths
	localparam int OP_W     = 2;
	localparam int HANDLE_W = 3;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 3;

	localparam logic [TIME_W-1:0] ALL_ONES = '1;

	// operation codes
	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
	localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BASELINE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage

`default_nettype wire

// File: rtl/pjm_in_if.sv
// ----------------------------------------------------------------------------
// pjm_in_if
// Request channel: operation, slot handle, period and current time.
// ----------------------------------------------------------------------------
`default_nettype none

interface pjm_in_if import pjm_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [HANDLE_W-1:0] handle;
	logic [TIME_W-1:0]   period_len;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, operation, handle, period_len, now_ms, input ready);
	modport sink   (input valid, operation, handle, period_len, now_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/pjm_out_if.sv
// ----------------------------------------------------------------------------
// pjm_out_if
// Response channel: status, slot and monitor statistics.
// ----------------------------------------------------------------------------
`default_nettype none

interface pjm_out_if import pjm_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] slot;
	logic [TIME_W-1:0]   period_out;
	logic [TIME_W-1:0]   min_jitter;
	logic [TIME_W-1:0]   max_jitter;
	logic [TIME_W-1:0]   mean_jitter;
	logic [TIME_W-1:0]   samples;

	modport source (output valid, status, slot, period_out, min_jitter, max_jitter,
		mean_jitter, samples, input ready);
	modport sink   (input valid, status, slot, period_out, min_jitter, max_jitter,
		mean_jitter, samples, output ready);
endinterface

`default_nettype wire

// File: rtl/pjm_divider.sv
// ----------------------------------------------------------------------------
// pjm_divider
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// valid in the cycle where done is high and holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pjm_divider import pjm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              done,
	output logic [TIME_W-1:0] quotient
);

	localparam int CNT_W = $clog2(TIME_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [TIME_W-1:0] div_q;

	logic [TIME_W:0]   rem_shift;
	logic [TIME_W+1:0] diff;

	// trial subtract of the shifted remainder
	assign rem_shift = {rem_q, quo_q[TIME_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[TIME_W+1]) begin
				rem_q <= diff[TIME_W-1:0];
				quo_q <= {quo_q[TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[TIME_W-1:0];
				quo_q <= {quo_q[TIME_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/periodic_jitter_monitor_table.sv
// ----------------------------------------------------------------------------
// periodic_jitter_monitor_table
// Table of periodic-event monitors: create claims a slot, mark sets the
// baseline, then records deviation from expected time; report returns statistics.
//
//   channel  role    handshake      payload
//   req      sink    valid/ready    operation, handle, period_len, now_ms
//   rsp      source  valid/ready    status, slot, period_out, min_jitter,
//                                   max_jitter, mean_jitter, samples
//
// One request at a time; req.ready is high only while the sequencer is idle.
// A request passes the states EXE and EMIT for create, failed ops and baseline
// marks, EXE, UPD and EMIT for an update mark, and EXE, DIV and EMIT for a
// report with samples (DIV waits on the bit-serial divider for the average).
// Per-slot state sits in one synchronous memory, read at request transfer
// and written back after compute. Of the per-slot state, reset clears only
// the slot-used flags; no clearing pass. A result still held on rsp blocks
// the next request at its emit step, so req.ready stays low until it transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_jitter_monitor_table import pjm_pkg::*; #(
	parameter int MONITOR_COUNT = MONITOR_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pjm_in_if.sink    req,
	pjm_out_if.source rsp
);

	localparam int IDX_W = (MONITOR_COUNT > 1) ? $clog2(MONITOR_COUNT) : 1;

	// per-slot memory entry
	typedef struct packed {
		logic              baseline;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] expected;
		logic [TIME_W-1:0] min_j;
		logic [TIME_W-1:0] max_j;
		logic [TIME_W-1:0] sum;
		logic [TIME_W-1:0] count;
	} ent_t;

	// result record
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] slot;
		logic [TIME_W-1:0]   period_out;
		logic [TIME_W-1:0]   min_jitter;
		logic [TIME_W-1:0]   max_jitter;
		logic [TIME_W-1:0]   mean_jitter;
		logic [TIME_W-1:0]   samples;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXE  = 5'b00010,
		S_UPD  = 5'b00100,
		S_DIV  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t               state_q;
	logic [MONITOR_COUNT-1:0] used_q;
	logic                 out_valid_q;

	logic [OP_W-1:0]      op_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [TIME_W-1:0]    period_q;
	logic [TIME_W-1:0]    now_q;
	ent_t                 ent_mem_q [MONITOR_COUNT];
	ent_t                 ent_rd_q;
	logic [TIME_W-1:0]    jit_q;
	res_t                 res_q;
	res_t                 out_q;

	logic                 acc;
	logic                 out_load;
	logic [IDX_W-1:0]     req_idx;
	logic [IDX_W-1:0]     hidx;
	logic                 hit;
	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic [TIME_W-1:0]    diff;
	logic [TIME_W-1:0]    jit;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_widx;
	ent_t                 mem_wdata;
	res_t                 res_nxt;
	logic                 div_start;
	logic                 div_done;
	logic [TIME_W-1:0]    div_quo;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	assign req_idx = IDX_W'(req.handle);
	assign hidx    = IDX_W'(handle_q);
	assign hit     = (32'(handle_q) < MONITOR_COUNT) && used_q[hidx];

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MONITOR_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// absolute deviation from the expected time
	assign diff = now_q - ent_rd_q.expected;
	assign jit  = diff[TIME_W-1] ? (TIME_W'(0) - diff) : diff;

	// memory write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_widx  = hidx;
		mem_wdata = ent_rd_q;
		if (state_q == S_EXE) begin
			if (op_q == OP_CREATE) begin
				mem_we             = free_found;
				mem_widx           = free_idx;
				mem_wdata.baseline = 1'b0;
				mem_wdata.period   = period_q;
				mem_wdata.expected = '0;
				mem_wdata.min_j    = ALL_ONES;
				mem_wdata.max_j    = '0;
				mem_wdata.sum      = '0;
				mem_wdata.count    = '0;
			end else if (op_q == OP_MARK && hit && !ent_rd_q.baseline) begin
				mem_we             = 1'b1;
				mem_wdata.baseline = 1'b1;
				mem_wdata.expected = now_q + ent_rd_q.period;
			end
		end else if (state_q == S_UPD) begin
			mem_we             = 1'b1;
			mem_wdata.expected = ent_rd_q.expected + ent_rd_q.period;
			mem_wdata.sum      = ent_rd_q.sum + jit_q;
			mem_wdata.count    = ent_rd_q.count + 1'b1;
			if (jit_q < ent_rd_q.min_j) begin
				mem_wdata.min_j = jit_q;
			end
			if (jit_q > ent_rd_q.max_j) begin
				mem_wdata.max_j = jit_q;
			end
		end
	end

	// state memory, one read and one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ent_mem_q[mem_widx] <= mem_wdata;
		end
		if (acc) begin
			ent_rd_q <= ent_mem_q[req_idx];
		end
	end

	// result of the compute cycle
	always_comb begin
		res_nxt        = '0;
		res_nxt.status = ST_UNUSED;
		res_nxt.slot   = handle_q;
		case (op_q)
			OP_CREATE: begin
				res_nxt.status = free_found ? ST_OK : ST_FULL;
				res_nxt.slot   = free_found ? HANDLE_W'(free_idx) : '0;
			end
			OP_MARK: begin
				if (hit) begin
					res_nxt.status = ent_rd_q.baseline ? ST_OK : ST_BASELINE;
				end
			end
			OP_REPORT: begin
				if (hit) begin
					res_nxt.period_out = ent_rd_q.period;
					res_nxt.min_jitter = ent_rd_q.min_j;
					res_nxt.max_jitter = ent_rd_q.max_j;
					res_nxt.samples    = ent_rd_q.count;
					res_nxt.status     = (ent_rd_q.count == '0) ? ST_EMPTY : ST_OK;
				end
			end
			default: begin
				res_nxt.status = ST_UNUSED;
			end
		endcase
	end

	assign div_start = (state_q == S_EXE) && (op_q == OP_REPORT) && hit &&
		(ent_rd_q.count != '0);

	pjm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ent_rd_q.sum),
		.divisor  (ent_rd_q.count),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer and slot-used flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_EXE;
					end
				end
				S_EXE: begin
					if (op_q == OP_CREATE && free_found) begin
						used_q[free_idx] <= 1'b1;
					end
					if (op_q == OP_MARK && hit && ent_rd_q.baseline) begin
						state_q <= S_UPD;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_UPD: begin
					state_q <= S_EMIT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, result and output registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= req.operation;
			handle_q <= req.handle;
			period_q <= req.period_len;
			now_q    <= req.now_ms;
		end
		if (state_q == S_EXE) begin
			res_q <= res_nxt;
			jit_q <= jit;
		end
		if (state_q == S_DIV && div_done) begin
			res_q.mean_jitter <= div_quo;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.slot        = out_q.slot;
	assign rsp.period_out  = out_q.period_out;
	assign rsp.min_jitter  = out_q.min_jitter;
	assign rsp.max_jitter  = out_q.max_jitter;
	assign rsp.mean_jitter = out_q.mean_jitter;
	assign rsp.samples     = out_q.samples;

endmodule

`default_nettype wire
